### rtl/hcpe_pkg.sv
`default_nettype none

package hcpe_pkg;

  // Field widths of the streaming payload.
  localparam int COORD_W   = 24;
  localparam int SAMPLE_W  = 12;
  localparam int COUNT_W   = 13;
  localparam int NUM_SLOTS = 4;
  localparam int NUM_AXES  = 3;
  localparam int S_DATA_W  = 88;
  localparam int M_DATA_W  = 72;
  localparam int S_USER_W  = 3;

  // Sample count limits and the reset value of the count register.
  localparam int MAX_SAMPLES = 4096;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd200;

  // Curve parameter t: unsigned, 16 fraction bits, 1.0 held exactly.
  localparam int T_W       = 17;
  localparam int TSQ_W     = 2 * T_W;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam int DIV_STEPS = T_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Basis terms carry 24 fraction bits.
  localparam int BASIS_W = 27;
  localparam int HSUM_W  = 28;
  localparam logic signed [HSUM_W-1:0] ONE_Q24 = 28'sd16777216;

  // Shared multiplier and accumulator.
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = BASIS_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 52;
  localparam int SHIFT_Q = 24;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [BASIS_W-1:0] basis_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SQ,
    S_CUBE,
    S_BASIS,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/hermite_curve_point_evaluator_unit.sv
// Load request: no result; the unit stays idle and keeps s_axis_tready high.
// Evaluate request: 17 steps of the bit-serial t divider, then 14 passes through
// the single shared multiplier (t squared, t cubed, 12 MACs); no new request is
// taken until the result moves into the output register, held while it is full.
// Reset clears the control vectors, sets the sample count to 200 and drops any
// pending result.
`default_nettype none

module hermite_curve_point_evaluator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: coord_x, coord_y, coord_z, sample, zero padding (lowest bit up)
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hcpe_pkg::S_DATA_W-1:0] s_axis_tdata,
  // tuser: op, slot (lowest bit up)
  input  logic [hcpe_pkg::S_USER_W-1:0] s_axis_tuser,
  // tdata: point_x, point_y, point_z (lowest bit up)
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hcpe_pkg::M_DATA_W-1:0] m_axis_tdata,
  // tuser: clipped
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [hcpe_pkg::COUNT_W-1:0]  cfg_wdata_i
);

  localparam int CW = hcpe_pkg::COORD_W;

  hcpe_pkg::state_e state_q, state_d;

  logic [hcpe_pkg::COUNT_W-1:0]  point_count_q;
  hcpe_pkg::coord_t              cv_q [hcpe_pkg::NUM_SLOTS][hcpe_pkg::NUM_AXES];

  logic [hcpe_pkg::SAMPLE_W-1:0] d_q;
  logic                          one_q;
  logic [hcpe_pkg::SAMPLE_W:0]   r_q;
  logic [hcpe_pkg::T_W-1:0]      q_q;
  logic [hcpe_pkg::STEP_W-1:0]   step_q;

  logic [hcpe_pkg::SHIFT_Q:0]    t2_q;
  hcpe_pkg::basis_t              basis_q [hcpe_pkg::NUM_SLOTS];
  logic [1:0]                    s_q;
  logic [1:0]                    axis_q;

  logic signed [hcpe_pkg::PROD_W-1:0] prod_q;
  logic                               prod_vld_q;
  logic                               prod_first_q;
  logic                               prod_last_q;
  logic [1:0]                         prod_axis_q;
  logic signed [hcpe_pkg::ACC_W-1:0]  acc_q;
  hcpe_pkg::coord_t                   pt_q [hcpe_pkg::NUM_AXES];
  logic                               clip_q;

  logic [hcpe_pkg::M_DATA_W-1:0] out_data_q;
  logic                          out_clip_q;
  logic                          out_valid_q;

  // Request fields.
  hcpe_pkg::op_e                 in_op;
  logic [1:0]                    in_slot;
  hcpe_pkg::coord_t              in_coord [hcpe_pkg::NUM_AXES];
  logic [hcpe_pkg::SAMPLE_W-1:0] in_sample;
  logic                          in_accept;

  assign in_op       = hcpe_pkg::op_e'(s_axis_tuser[0]);
  assign in_slot     = s_axis_tuser[2:1];
  assign in_coord[0] = s_axis_tdata[CW-1:0];
  assign in_coord[1] = s_axis_tdata[2*CW-1:CW];
  assign in_coord[2] = s_axis_tdata[3*CW-1:2*CW];
  assign in_sample   = s_axis_tdata[3*CW+hcpe_pkg::SAMPLE_W-1:3*CW];
  assign in_accept   = s_axis_tvalid && s_axis_tready;

  // Divisor count-1 with the count clamped to 1..MAX_SAMPLES; sample clamped to it.
  logic [hcpe_pkg::COUNT_W-1:0]  count_m1;
  logic [hcpe_pkg::SAMPLE_W-1:0] div_den;
  logic [hcpe_pkg::SAMPLE_W-1:0] idx;

  always_comb begin
    count_m1 = point_count_q - hcpe_pkg::COUNT_W'(1);
    if (point_count_q == '0) begin
      div_den = '0;
    end else if (point_count_q > hcpe_pkg::COUNT_W'(hcpe_pkg::MAX_SAMPLES)) begin
      div_den = hcpe_pkg::SAMPLE_W'(hcpe_pkg::MAX_SAMPLES - 1);
    end else begin
      div_den = count_m1[hcpe_pkg::SAMPLE_W-1:0];
    end
    idx = (in_sample > div_den) ? div_den : in_sample;
  end

  // One restoring division step: a quotient bit of sample * 2^16 / (count-1).
  logic                        div_ge;
  logic [hcpe_pkg::SAMPLE_W:0] div_rem;
  logic                        div_last;

  always_comb begin
    div_ge   = r_q >= {1'b0, d_q};
    div_rem  = div_ge ? (r_q - {1'b0, d_q}) : r_q;
    div_last = step_q == hcpe_pkg::STEP_W'(hcpe_pkg::DIV_STEPS - 1);
  end

  // Hermite basis from t, t^2 and t^3 (t^3 still sits in the product register).
  logic signed [hcpe_pkg::HSUM_W-1:0] e1, e2, e3;
  logic signed [hcpe_pkg::HSUM_W-1:0] h1, h2, h3, h4;

  always_comb begin
    e1 = $signed(hcpe_pkg::HSUM_W'({q_q, 8'b0}));
    e2 = $signed(hcpe_pkg::HSUM_W'(t2_q));
    e3 = $signed(hcpe_pkg::HSUM_W'(prod_q[2*hcpe_pkg::SHIFT_Q:hcpe_pkg::SHIFT_Q]));
    h1 = (e3 <<< 1) - (e2 + (e2 <<< 1)) + hcpe_pkg::ONE_Q24;
    h2 = (e2 + (e2 <<< 1)) - (e3 <<< 1);
    h3 = e3 - (e2 <<< 1) + e1;
    h4 = e3 - e2;
  end

  // Shared multiplier operand selection.
  logic signed [hcpe_pkg::MUL_A_W-1:0] mul_a;
  logic signed [hcpe_pkg::MUL_B_W-1:0] mul_b;
  logic signed [hcpe_pkg::PROD_W-1:0]  mul_p;

  always_comb begin
    case (state_q)
      hcpe_pkg::S_SQ: begin
        mul_a = $signed(hcpe_pkg::MUL_A_W'(q_q));
        mul_b = $signed(hcpe_pkg::MUL_B_W'(q_q));
      end
      hcpe_pkg::S_CUBE: begin
        mul_a = $signed(hcpe_pkg::MUL_A_W'(prod_q[hcpe_pkg::TSQ_W-1:0]));
        mul_b = $signed(hcpe_pkg::MUL_B_W'(q_q));
      end
      default: begin
        mul_a = hcpe_pkg::MUL_A_W'(cv_q[s_q][axis_q]);
        mul_b = basis_q[s_q];
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Accumulation, floor to 16 fraction bits and saturation.
  logic signed [hcpe_pkg::ACC_W-1:0] acc_sum;
  logic [hcpe_pkg::ACC_W-hcpe_pkg::SHIFT_Q-CW:0] acc_hi;
  logic                              acc_fits;
  hcpe_pkg::coord_t                  acc_sat;

  always_comb begin
    acc_sum  = (prod_first_q ? '0 : acc_q) + $signed(prod_q[hcpe_pkg::ACC_W-1:0]);
    acc_hi   = acc_sum[hcpe_pkg::ACC_W-1:hcpe_pkg::SHIFT_Q+CW-1];
    acc_fits = (acc_hi == '0) || (acc_hi == '1);
    if (acc_fits) begin
      acc_sat = acc_sum[hcpe_pkg::SHIFT_Q+CW-1:hcpe_pkg::SHIFT_Q];
    end else if (acc_sum[hcpe_pkg::ACC_W-1]) begin
      acc_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(CW-1){1'b1}}};
    end
  end

  // Sequencer: next state and handshake.
  logic out_load;
  logic mac_last;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mac_last      = (axis_q == 2'(hcpe_pkg::NUM_AXES - 1)) &&
                    (s_q == 2'(hcpe_pkg::NUM_SLOTS - 1));
    case (state_q)
      hcpe_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (in_op == hcpe_pkg::OP_EVAL)) begin
          state_d = hcpe_pkg::S_DIV;
        end
      end
      hcpe_pkg::S_DIV: begin
        if (div_last) begin
          state_d = hcpe_pkg::S_SQ;
        end
      end
      hcpe_pkg::S_SQ:    state_d = hcpe_pkg::S_CUBE;
      hcpe_pkg::S_CUBE:  state_d = hcpe_pkg::S_BASIS;
      hcpe_pkg::S_BASIS: state_d = hcpe_pkg::S_MAC;
      hcpe_pkg::S_MAC: begin
        if (mac_last) begin
          state_d = hcpe_pkg::S_DRAIN;
        end
      end
      hcpe_pkg::S_DRAIN: state_d = hcpe_pkg::S_DONE;
      hcpe_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = hcpe_pkg::S_IDLE;
        end
      end
      default: state_d = hcpe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcpe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register and the control vector store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= hcpe_pkg::COUNT_RESET;
      for (int s = 0; s < hcpe_pkg::NUM_SLOTS; s++) begin
        for (int a = 0; a < hcpe_pkg::NUM_AXES; a++) begin
          cv_q[s][a] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if (in_accept && (in_op == hcpe_pkg::OP_LOAD)) begin
        for (int a = 0; a < hcpe_pkg::NUM_AXES; a++) begin
          cv_q[in_slot][a] <= in_coord[a];
        end
      end
    end
  end

  // Sequencer counters and pipeline flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      s_q         <= '0;
      axis_q      <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prod_vld_q <= state_q == hcpe_pkg::S_MAC;
      if (in_accept) begin
        step_q <= '0;
      end else if (state_q == hcpe_pkg::S_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == hcpe_pkg::S_BASIS) begin
        s_q    <= '0;
        axis_q <= '0;
      end else if (state_q == hcpe_pkg::S_MAC) begin
        s_q <= s_q + 1'b1;
        if (s_q == 2'(hcpe_pkg::NUM_SLOTS - 1)) begin
          axis_q <= axis_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: divider, powers of t, basis, products and accumulation.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      r_q   <= {1'b0, idx};
      d_q   <= div_den;
      one_q <= div_den == '0;
      q_q   <= '0;
    end else if (state_q == hcpe_pkg::S_DIV) begin
      r_q <= {div_rem[hcpe_pkg::SAMPLE_W-1:0], 1'b0};
      // A count of one pins t to the curve start.
      q_q <= (div_last && one_q) ? '0 : {q_q[hcpe_pkg::T_W-2:0], div_ge};
    end

    case (state_q)
      hcpe_pkg::S_SQ: prod_q <= mul_p;
      hcpe_pkg::S_CUBE: begin
        prod_q <= mul_p;
        t2_q   <= prod_q[hcpe_pkg::TSQ_W-2:8];
      end
      hcpe_pkg::S_BASIS: begin
        basis_q[0] <= h1[hcpe_pkg::BASIS_W-1:0];
        basis_q[1] <= h2[hcpe_pkg::BASIS_W-1:0];
        basis_q[2] <= h3[hcpe_pkg::BASIS_W-1:0];
        basis_q[3] <= h4[hcpe_pkg::BASIS_W-1:0];
        clip_q     <= 1'b0;
      end
      hcpe_pkg::S_MAC: begin
        prod_q       <= mul_p;
        prod_first_q <= s_q == '0;
        prod_last_q  <= s_q == 2'(hcpe_pkg::NUM_SLOTS - 1);
        prod_axis_q  <= axis_q;
      end
      default: ;
    endcase

    if (prod_vld_q) begin
      acc_q <= acc_sum;
      if (prod_last_q) begin
        pt_q[prod_axis_q] <= acc_sat;
        clip_q            <= clip_q | !acc_fits;
      end
    end

    if (out_load) begin
      out_data_q <= {pt_q[2], pt_q[1], pt_q[0]};
      out_clip_q <= clip_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clip_q;

  // The partial remainder stays below twice the divisor throughout the division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == hcpe_pkg::S_DIV) && !one_q) |-> (r_q < {d_q, 1'b0}))
    else $error("divider remainder out of range");

  // The quotient t never exceeds 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hcpe_pkg::S_SQ) |-> (q_q <= hcpe_pkg::T_ONE))
    else $error("curve parameter above one");

  // A result only appears as the sequencer completes an evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == hcpe_pkg::S_DONE))
    else $error("result raised outside completion");

  // Products in flight always belong to a real axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> (prod_axis_q < 2'(hcpe_pkg::NUM_AXES)))
    else $error("product tagged with an invalid axis");

  // The multiply-accumulate phase is entered only from the basis step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == hcpe_pkg::S_MAC) |-> ($past(state_q) == hcpe_pkg::S_BASIS))
    else $error("MAC phase entered out of sequence");

endmodule

`default_nettype wire

### tb/tb_hermite_curve_point_evaluator_unit.sv
`timescale 1ns / 100ps

module tb_hermite_curve_point_evaluator_unit;
  import hcpe_pkg::*;

  // Control vector slots.
  localparam logic [1:0] SLOT_START = 2'd0;
  localparam logic [1:0] SLOT_END   = 2'd1;
  localparam logic [1:0] SLOT_TAN0  = 2'd2;
  localparam logic [1:0] SLOT_TAN1  = 2'd3;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam coord_t COORD_ONE = 24'sh010000;

  typedef struct packed {
    op_e                 op;
    logic [1:0]          slot;
    coord_t              cx;
    coord_t              cy;
    coord_t              cz;
    logic [SAMPLE_W-1:0] sample;
  } curve_req_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
    logic   clipped;
  } curve_point_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  // Predictor state: control store and sample count as the block should hold them.
  coord_t             ctl_vec [NUM_SLOTS][NUM_AXES];
  logic [COUNT_W-1:0] sample_count = COUNT_RESET;

  curve_req_t   pending_reqs [$];
  curve_point_t expected_points [$];
  curve_req_t   cur_req;
  int           err_count = 0;
  int           tx_wait = 0;
  int           rx_wait = 0;
  logic         calm = 1'b0;

  hermite_curve_point_evaluator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("tb_hermite_curve_point_evaluator_unit failed");
    $finish;
  end

  // Curve point for one sample index, from the current control store and count.
  function automatic curve_point_t hermite_point(logic [SAMPLE_W-1:0] sample);
    longint cnt, idx, tq, t2, t3, acc, p;
    longint h [NUM_SLOTS];
    longint hi_lim, lo_lim;
    coord_t res [NUM_AXES];
    curve_point_t r;
    cnt = longint'(sample_count);
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_SAMPLES) cnt = MAX_SAMPLES;
    idx = longint'(sample);
    if (idx > cnt - 1) idx = cnt - 1;
    tq = (cnt == 1) ? 0 : (idx * 65536) / (cnt - 1);
    t2 = (tq * tq) >>> 8;
    t3 = (tq * tq * tq) >>> 24;
    h[0] = 2 * t3 - 3 * t2 + (64'sd1 <<< 24);
    h[1] = -2 * t3 + 3 * t2;
    h[2] = t3 - 2 * t2 + (tq <<< 8);
    h[3] = t3 - t2;
    hi_lim = (64'sd1 <<< (COORD_W - 1)) - 1;
    lo_lim = -hi_lim - 1;
    r.clipped = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      acc = 0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        acc += h[s] * longint'(ctl_vec[s][a]);
      end
      // Arithmetic shift rounds toward minus infinity.
      p = acc >>> 24;
      if (p > hi_lim) begin
        p = hi_lim;
        r.clipped = 1'b1;
      end
      if (p < lo_lim) begin
        p = lo_lim;
        r.clipped = 1'b1;
      end
      res[a] = coord_t'(p);
    end
    r.px = res[0];
    r.py = res[1];
    r.pz = res[2];
    return r;
  endfunction

  // Loads update the store; evaluate requests queue an expected point.
  task automatic take_request(curve_req_t r);
    if (r.op == OP_LOAD) begin
      ctl_vec[r.slot][0] = r.cx;
      ctl_vec[r.slot][1] = r.cy;
      ctl_vec[r.slot][2] = r.cz;
    end else begin
      expected_points.push_back(hermite_point(r.sample));
    end
  endtask

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic int gap_draw();
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  // Occasionally switch between randomly gapped and back-to-back stretches.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 79) == 0) calm <= !calm;
  end

  // Request driver.
  always @(posedge clk_i) begin : drv_p
    curve_req_t nxt;
    if (rst_ni) begin
      if (s_valid && s_axis_tready) take_request(cur_req);
      if (!s_valid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          cur_req = nxt;
          s_tdata <= {4'b0, nxt.sample, nxt.cz, nxt.cy, nxt.cx};
          s_tuser <= {nxt.slot, nxt.op};
          s_valid <= 1'b1;
          tx_wait = gap_draw();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin : mon_p
    curve_point_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = expected_points.pop_front();
          if (m_axis_tdata[23:0] !== want.px)
            report_mismatch($sformatf("point_x %h, want %h", m_axis_tdata[23:0], want.px));
          if (m_axis_tdata[47:24] !== want.py)
            report_mismatch($sformatf("point_y %h, want %h", m_axis_tdata[47:24], want.py));
          if (m_axis_tdata[71:48] !== want.pz)
            report_mismatch($sformatf("point_z %h, want %h", m_axis_tdata[71:48], want.pz));
          if (m_axis_tuser !== want.clipped)
            report_mismatch($sformatf("clipped %b, want %b", m_axis_tuser, want.clipped));
        end
        rx_wait = gap_draw();
        m_ready <= (rx_wait == 0);
      end else if (!m_ready) begin
        if (rx_wait > 0) rx_wait--;
        m_ready <= (rx_wait == 0);
      end
    end
  end

  task automatic push_req(op_e op, logic [1:0] slot, coord_t x, coord_t y, coord_t z,
                          logic [SAMPLE_W-1:0] sample);
    curve_req_t r;
    r.op = op;
    r.slot = slot;
    r.cx = x;
    r.cy = y;
    r.cz = z;
    r.sample = sample;
    pending_reqs.push_back(r);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3, 4, 5: return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  // Sample index: mostly inside the current range, sometimes at or past its ends.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int eff;
    eff = (sample_count == 0) ? 1 : int'(sample_count);
    if (eff > MAX_SAMPLES) eff = MAX_SAMPLES;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SAMPLE_W'(eff - 1);
      2: return '1;
      3: return SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom_range(0, eff - 1));
    endcase
  endfunction

  // Mostly whole curves (four loads then evaluations), the rest single stray requests.
  task automatic random_batch(int n);
    int made;
    int nev;
    logic [1:0] first;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 3) != 0) begin
        first = 2'($urandom_range(0, 3));
        for (int k = 0; k < NUM_SLOTS; k++) begin
          push_req(OP_LOAD, first + 2'(k), rand_coord(), rand_coord(), rand_coord(),
                   SAMPLE_W'($urandom));
        end
        nev = $urandom_range(2, 8);
        for (int k = 0; k < nev; k++) begin
          push_req(OP_EVAL, 2'($urandom), rand_coord(), rand_coord(), rand_coord(),
                   rand_sample());
        end
        made += NUM_SLOTS + nev;
      end else begin
        push_req(op_e'($urandom_range(0, 1)), 2'($urandom), rand_coord(), rand_coord(),
                 rand_coord(), rand_sample());
        made++;
      end
    end
  endtask

  // Wait until every request is taken and every point has come, then let the block settle.
  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (pending_reqs.size() != 0 || s_valid || expected_points.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_count(logic [COUNT_W-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sample_count = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stim_p
    logic [COUNT_W-1:0] plan [$];
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int a = 0; a < NUM_AXES; a++) ctl_vec[s][a] = '0;
    end
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // Directed part at the reset count: empty store, full-scale vectors, clamping,
    // ignored fields, then a plain unit curve.
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd0);
    push_req(OP_LOAD, SLOT_START, COORD_MAX, COORD_MIN, 24'sd1, '0);
    push_req(OP_LOAD, SLOT_END, COORD_MIN, COORD_MAX, -24'sd1, '0);
    push_req(OP_LOAD, SLOT_TAN0, COORD_MAX, COORD_MAX, COORD_MIN, '0);
    push_req(OP_LOAD, SLOT_TAN1, COORD_MIN, COORD_MIN, COORD_MAX, '0);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd0);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd199);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd4095);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd100);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd1);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd198);
    push_req(OP_LOAD, SLOT_START, '0, '0, '0, 12'hFFF);
    push_req(OP_EVAL, SLOT_TAN1, COORD_MAX, COORD_MAX, COORD_MAX, 12'd50);
    push_req(OP_LOAD, SLOT_END, COORD_ONE, COORD_ONE, -COORD_ONE, '0);
    push_req(OP_LOAD, SLOT_TAN0, COORD_ONE, '0, 24'sd3, '0);
    push_req(OP_LOAD, SLOT_TAN1, '0, -COORD_ONE, -24'sd3, '0);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd0);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd99);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd199);
    push_req(OP_LOAD, SLOT_TAN1, COORD_MIN, COORD_MIN, COORD_MIN, '0);
    push_req(OP_EVAL, SLOT_START, '0, '0, '0, 12'd150);
    random_batch(130);
    wait_quiet();

    // Count settings: degenerate counts, the largest legal one, values beyond it, small and random ones.
    plan = '{13'd1, 13'd0, 13'd2, 13'd4096, 13'd8191, 13'd4097, 13'd3, 13'd17};
    plan.push_back(COUNT_W'($urandom_range(4, 4095)));
    plan.push_back(COUNT_W'($urandom_range(0, 8191)));
    foreach (plan[i]) begin
      write_count(plan[i]);
      random_batch(130);
      wait_quiet();
    end

    if (err_count == 0) begin
      $display("tb_hermite_curve_point_evaluator_unit passed");
    end else begin
      $display("tb_hermite_curve_point_evaluator_unit failed");
    end
    $finish;
  end

endmodule
